@@ hw/rtl/disc_track_map_translator_core_defines.svh @@
// Assertion macros used by the track map translator RTL.
`ifndef DISC_TRACK_MAP_TRANSLATOR_CORE_DEFINES_SVH
`define DISC_TRACK_MAP_TRANSLATOR_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define DTMT_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the condition.
`define DTMT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/dtmt_pkg.sv @@
// ----------------------------------------------------------------------------
// dtmt_pkg
// Types and constants of the disc track map translator.
// ----------------------------------------------------------------------------
`default_nettype none

package dtmt_pkg;

    localparam logic [1:0] OP_CLEAR     = 2'd0;
    localparam logic [1:0] OP_APPEND    = 2'd1;
    localparam logic [1:0] OP_TRANSLATE = 2'd2;
    localparam logic [1:0] OP_QUERY     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_TRACK = 2'd2;

    localparam logic [4:0] RAW_HEADER = 5'd16;

    typedef struct packed {
        logic [1:0]  operation;
        logic [18:0] track_frames;
        logic [18:0] pregap_frames;
        logic [18:0] postgap_frames;
        logic        track_audio;
        logic        track_raw;
        logic        pregap_stored;
        logic [19:0] disc_frame;
        logic [7:0]  track_number;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  track_index;
        logic [19:0] disc_start;
        logic [19:0] image_frame;
        logic [18:0] length_frames;
        logic        audio;
        logic [19:0] hunk_number;
        logic [5:0]  frame_in_hunk;
        logic        hunk_miss;
        logic [4:0]  data_offset;
        logic [19:0] leadout;
    } rsp_t;

    // One stored track: disc start, image start, length, audio, raw.
    typedef struct packed {
        logic [19:0] disc_start;
        logic [19:0] image_start;
        logic [18:0] length;
        logic        audio;
        logic        raw;
    } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/disc_track_map_translator_core.sv @@
// ----------------------------------------------------------------------------
// disc_track_map_translator_core
// Track table of a compressed disc image with clear, append, translate and query.
// ----------------------------------------------------------------------------
//  channel   | ports                        | handshake
//  command   | start, cmd                   | start && !busy
//  result    | done, rsp                    | done, one cycle, no stall
//  config    | cfg_we, cfg_data             | cfg_we
//
// Steps from the accepting edge to the result: a clear finishes from idle,
// an append in its own state, a query reads the entry and then returns it (a
// bad track number finishes in the read state), and a translate does one read
// and one compare per entry scanning down from the newest, then 20 restoring
// division steps by the hunk size and a final state to update the cached hunk.
// busy is high from the cycle after the transfer until the result cycle; a
// clear never raises it. The receiver cannot stall, so results never wait.
// Reset is asynchronous; the table is not cleared and holds junk until written.
`default_nettype none
`include "disc_track_map_translator_core_defines.svh"

module disc_track_map_translator_core #(
    parameter int MAX_TRACKS = 128,
    parameter int PADDING    = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire dtmt_pkg::cmd_t  cmd,
    output logic                 busy,
    output logic                 done,
    output dtmt_pkg::rsp_t       rsp,
    input  wire logic            cfg_we,
    input  wire logic [6:0]      cfg_data
);

    localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW = $clog2(MAX_TRACKS + 1);
    localparam int PW = (PADDING > 1) ? $clog2(PADDING) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_APP   = 4'd1;
    localparam logic [3:0] S_QRD   = 4'd2;
    localparam logic [3:0] S_QOUT  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_SCHK  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_HUNK  = 4'd7;
    localparam logic [3:0] S_FIRST = 4'd8;

    // Track table memory.
    dtmt_pkg::entry_t mem [MAX_TRACKS];
    dtmt_pkg::entry_t rd_q;
    logic             mem_we;
    logic [AW-1:0]    wr_addr, rd_addr;
    dtmt_pkg::entry_t wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    logic [3:0]       state_reg, state_next;
    dtmt_pkg::cmd_t   cmd_reg, cmd_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [19:0]      disc_reg, disc_next;
    logic [19:0]      image_reg, image_next;
    logic             prev_data_reg, prev_data_next;
    logic             hunk_valid_reg, hunk_valid_next;
    logic [19:0]      hunk_reg, hunk_next;
    logic [6:0]       fph_reg;
    logic             first_raw_reg, first_raw_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [19:0]      rem_reg, rem_next;
    logic [19:0]      quo_reg, quo_next;
    logic [4:0]       bit_reg, bit_next;
    logic             done_reg, done_next;
    dtmt_pkg::rsp_t   rsp_reg, rsp_next;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fph_reg <= 7'd8;
        end
        else if (cfg_we)
        begin
            fph_reg <= cfg_data;
        end
    end

    // Clamped hunk size, 1 to 64.
    logic [6:0] fph;
    always_comb
    begin
        if (fph_reg == 7'd0)
        begin
            fph = 7'd1;
        end
        else if (fph_reg > 7'd64)
        begin
            fph = 7'd64;
        end
        else
        begin
            fph = fph_reg;
        end
    end

    // Append arithmetic, done in one state from registered state.
    logic [19:0] pad_img, img_pg, disc_pg;
    logic [18:0] len_a;
    logic        take_pg;
    logic [PW-1:0] pad_rem;
    always_comb
    begin
        if (PADDING > 1)
        begin
            pad_rem = PW'(image_reg % 20'(PADDING));
            pad_img = (pad_rem != '0)
                ? image_reg + 20'(PADDING) - 20'(pad_rem) : image_reg;
        end
        else
        begin
            pad_rem = '0;
            pad_img = image_reg;
        end
        take_pg = (cmd_reg.pregap_frames != 19'd0)
            && (!prev_data_reg || cmd_reg.pregap_stored);
        img_pg  = take_pg ? pad_img + 20'(cmd_reg.pregap_frames) : pad_img;
        len_a   = !take_pg ? cmd_reg.track_frames
                : (cmd_reg.track_frames > cmd_reg.pregap_frames)
                ? cmd_reg.track_frames - cmd_reg.pregap_frames : 19'd0;
        disc_pg = disc_reg + 20'(cmd_reg.pregap_frames);
    end

    // Restoring division step.
    logic [20:0] trial;
    always_comb
    begin
        trial = {rem_reg, quo_reg[19]} - 21'(fph);
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        disc_next       = disc_reg;
        image_next      = image_reg;
        prev_data_next  = prev_data_reg;
        hunk_valid_next = hunk_valid_reg;
        hunk_next       = hunk_reg;
        first_raw_next  = first_raw_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        bit_next        = bit_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = '0;
        rd_addr         = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    rsp_next = '0;
                    unique case (cmd.operation)
                        dtmt_pkg::OP_CLEAR:
                        begin
                            count_next      = '0;
                            disc_next       = '0;
                            image_next      = '0;
                            prev_data_next  = 1'b1;
                            hunk_valid_next = 1'b0;
                            hunk_next       = '0;
                            first_raw_next  = 1'b0;
                            done_next       = 1'b1;
                        end
                        dtmt_pkg::OP_APPEND:    state_next = S_APP;
                        dtmt_pkg::OP_TRANSLATE:
                        begin
                            idx_next   = count_reg;
                            state_next = S_SCAN;
                        end
                        dtmt_pkg::OP_QUERY:     state_next = S_QRD;
                    endcase
                    rsp_next.data_offset = (first_raw_reg && cmd.operation != dtmt_pkg::OP_CLEAR)
                        ? dtmt_pkg::RAW_HEADER : 5'd0;
                    rsp_next.leadout = (cmd.operation == dtmt_pkg::OP_CLEAR) ? 20'd0 : disc_reg;
                end
            end
            S_APP:
            begin
                if (count_reg >= CW'(MAX_TRACKS))
                begin
                    rsp_next.status = dtmt_pkg::ST_FULL;
                end
                else
                begin
                    mem_we             = 1'b1;
                    wr_data.disc_start = disc_pg;
                    wr_data.image_start = img_pg;
                    wr_data.length     = len_a;
                    wr_data.audio      = cmd_reg.track_audio;
                    wr_data.raw        = cmd_reg.track_raw;
                    image_next = img_pg + 20'(len_a);
                    disc_next  = disc_pg + 20'(len_a) + 20'(cmd_reg.postgap_frames);
                    prev_data_next = !cmd_reg.track_audio;
                    count_next = count_reg + CW'(1);
                    if (count_reg == '0)
                    begin
                        first_raw_next = cmd_reg.track_raw;
                    end
                    rsp_next.track_index   = 8'(count_reg) + 8'd1;
                    rsp_next.disc_start    = disc_pg;
                    rsp_next.image_frame   = img_pg;
                    rsp_next.length_frames = len_a;
                    rsp_next.audio         = cmd_reg.track_audio;
                    rsp_next.data_offset   = ((count_reg == '0) ? cmd_reg.track_raw
                        : first_raw_reg) ? dtmt_pkg::RAW_HEADER : 5'd0;
                    rsp_next.leadout = disc_pg + 20'(len_a) + 20'(cmd_reg.postgap_frames);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_QRD:
            begin
                rd_addr = AW'(cmd_reg.track_number - 8'd1);
                if (cmd_reg.track_number == 8'd0 || 9'(cmd_reg.track_number) > 9'(count_reg))
                begin
                    rsp_next.status = dtmt_pkg::ST_NO_TRACK;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_QOUT;
                end
            end
            S_QOUT:
            begin
                rsp_next.track_index   = cmd_reg.track_number;
                rsp_next.disc_start    = rd_q.disc_start;
                rsp_next.image_frame   = rd_q.image_start;
                rsp_next.length_frames = rd_q.length;
                rsp_next.audio         = rd_q.audio;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // Issue a read of entry idx-1, or with no entry left divide the disc frame.
                if (idx_reg == '0)
                begin
                    rsp_next.image_frame = cmd_reg.disc_frame;
                    quo_next   = cmd_reg.disc_frame;
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    rd_addr    = AW'(idx_reg - CW'(1));
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (cmd_reg.disc_frame >= rd_q.disc_start)
                begin
                    rsp_next.track_index   = 8'(idx_reg);
                    rsp_next.disc_start    = rd_q.disc_start;
                    rsp_next.length_frames = rd_q.length;
                    rsp_next.audio         = rd_q.audio;
                    rsp_next.image_frame   = rd_q.image_start
                        + (cmd_reg.disc_frame - rd_q.disc_start);
                    quo_next   = rd_q.image_start + (cmd_reg.disc_frame - rd_q.disc_start);
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    idx_next   = idx_reg - CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_DIV:
            begin
                // One quotient bit a cycle, MSB first.
                if (!trial[20])
                begin
                    rem_next = trial[19:0];
                    quo_next = {quo_reg[18:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[18:0], quo_reg[19]};
                    quo_next = {quo_reg[18:0], 1'b0};
                end
                bit_next = bit_reg + 5'd1;
                if (bit_reg == 5'd19)
                begin
                    state_next = S_HUNK;
                end
            end
            S_HUNK:
            begin
                rsp_next.hunk_number   = quo_reg;
                rsp_next.frame_in_hunk = rem_reg[5:0];
                rsp_next.hunk_miss     = !hunk_valid_reg || (hunk_reg != quo_reg);
                hunk_next       = quo_reg;
                hunk_valid_next = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            disc_reg       <= '0;
            image_reg      <= '0;
            prev_data_reg  <= 1'b1;
            hunk_valid_reg <= 1'b0;
            hunk_reg       <= '0;
            first_raw_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            disc_reg       <= disc_next;
            image_reg      <= image_next;
            prev_data_reg  <= prev_data_next;
            hunk_valid_reg <= hunk_valid_next;
            hunk_reg       <= hunk_next;
            first_raw_reg  <= first_raw_next;
            done_reg       <= done_next;
        end
    end

    // Payload and iteration registers.
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        idx_reg <= idx_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        bit_reg <= bit_next;
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `DTMT_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_reg <= CW'(MAX_TRACKS),
        "track count beyond table")
    `DTMT_ASSERT_IMP(a_scan_range, clk, rst_n, state_reg == S_SCHK,
        idx_reg != '0 && idx_reg <= count_reg, "scan index out of range")
    `DTMT_ASSERT_NEXT(a_hunk_done, clk, rst_n, state_reg == S_HUNK, done && hunk_valid_reg,
        "translate did not finish")
    `DTMT_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy, "result while still busy")

endmodule

`default_nettype wire
